/* src/esc_pkg.sv */
// Shared constants for the environmental sensor compensation pipeline.
// Used by the top level, the divider and the port checker; no dependencies.
package esc_pkg;

    // Item field widths
    localparam int RAW_T_W = 20;
    localparam int RAW_P_W = 20;
    localparam int RAW_H_W = 16;
    localparam int HUM_W   = 17;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 88;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_L = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_H = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIXED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUM    = 3'd4;

    // Divider word width (one quotient bit per stage)
    localparam int DIV_W = 64;

    // Formula constants
    localparam logic [63:0] T_FINE_OFS = 64'd128000;
    localparam logic [63:0] P_BASE     = 64'd1048576;
    localparam logic [63:0] P_SCALE    = 64'd3125;
    localparam logic [31:0] H_OFS      = 32'd76800;
    localparam logic [31:0] H_MAX      = 32'd419430400;
    localparam logic [31:0] H_BIAS     = 32'd2097152;
    localparam logic [31:0] H_RND14    = 32'd16384;
    localparam logic [31:0] H_RND_H3   = 32'd32768;
    localparam logic [31:0] H_RND_H2   = 32'd8192;
    localparam logic [16:0] HUM_LIMIT  = 17'd102400;

endpackage

/* src/esc_mul.sv */
// Two-stage 64x64 multiplier giving the low 64 bits of the product.
// Built from 32x32 partial products; no package dependency.
module esc_mul
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0] ll_c;
    logic [63:0] lh_c;
    logic [63:0] hl_c;
    logic [63:0] ll_reg;
    logic [31:0] x_reg;
    logic [63:0] p_reg;

    // partial products, only the low word of the cross terms matters
    assign ll_c = a[31:0] * b[31:0];
    assign lh_c = a[31:0] * b[63:32];
    assign hl_c = a[63:32] * b[31:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ll_c;
            x_reg  <= lh_c[31:0] + hl_c[31:0];
            p_reg  <= ll_reg + {x_reg, 32'b0};
        end
    end

    assign p = p_reg;

endmodule

/* src/esc_div.sv */
// Pipelined signed 64-bit divider, one quotient bit per stage.
// The operand magnitudes, each restoring step and the sign fixup are registered; depends on esc_pkg.
module esc_div
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic [63:0] quo
);

    localparam int N = esc_pkg::DIV_W;

    logic [N-1:0] r_reg  [0:N];
    logic [N-1:0] nq_reg [0:N];
    logic [N-1:0] d_reg  [0:N];
    logic         ng_reg [0:N];
    logic [N-1:0] quo_reg;
    logic [N-1:0] an_c;
    logic [N-1:0] ad_c;

    // magnitudes; the most negative value maps onto itself as unsigned
    assign an_c = num[N-1] ? (~num + 1'b1) : num;
    assign ad_c = den[N-1] ? (~den + 1'b1) : den;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]  <= '0;
            nq_reg[0] <= an_c;
            d_reg[0]  <= ad_c;
            ng_reg[0] <= num[N-1] ^ den[N-1];
        end
    end

    // restoring steps
    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [N:0] t_c;
        logic [N:0] diff_c;
        logic       ge_c;

        assign t_c    = {r_reg[k], nq_reg[k][N-1]};
        assign diff_c = t_c - {1'b0, d_reg[k]};
        assign ge_c   = (t_c >= {1'b0, d_reg[k]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k+1]  <= ge_c ? diff_c[N-1:0] : t_c[N-1:0];
                nq_reg[k+1] <= {nq_reg[k][N-2:0], ge_c};
                d_reg[k+1]  <= d_reg[k];
                ng_reg[k+1] <= ng_reg[k];
            end
        end
    end

    // sign fixup
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= ng_reg[N] ? (~nq_reg[N] + 1'b1) : nq_reg[N];
        end
    end

    assign quo = quo_reg;

endmodule

/* src/environmental_sensor_compensation_top.sv */
// Top level: integer temperature, pressure and humidity compensation pipeline.
// Depends on esc_pkg, esc_mul and esc_div.
//
// One raw sample triple enters per clock while the output buffer is not full;
// its compensated result is pushed into that buffer. Depth is set by the
// pressure path: the 64-bit signed division runs one quotient bit per stage
// (66 stages), framed by two-stage 64-bit multipliers. Temperature and
// humidity are computed alongside and delayed to meet it. A two-entry output
// buffer lets the pipeline keep accepting while one result waits; the whole
// pipeline holds only when both entries are full. Coefficients are written
// through cfg_we/cfg_index/cfg_data and must only change while idle.
module environmental_sensor_compensation_top
(
    input  logic        clk,
    input  logic        rst_n,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20],
                                   // raw_humidity[55:40]
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // temperature_centi[31:0], pressure_q24_8[63:32],
                                   // humidity_q7_10[80:64], zero pad[87:81]
    output logic        m_tuser,   // pressure_invalid
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int LAST = 84;

    // ------------------------------------------------------------------
    // Coefficient registers
    logic [47:0] tc_reg;
    logic [63:0] pl_reg;
    logic [63:0] ph_reg;
    logic [47:0] mx_reg;
    logic [39:0] hc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg <= '0;
            pl_reg <= '0;
            ph_reg <= '0;
            mx_reg <= '0;
            hc_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                esc_pkg::REG_TEMP:    tc_reg <= cfg_data[47:0];
                esc_pkg::REG_PRESS_L: pl_reg <= cfg_data;
                esc_pkg::REG_PRESS_H: ph_reg <= cfg_data;
                esc_pkg::REG_MIXED:   mx_reg <= cfg_data[47:0];
                esc_pkg::REG_HUM:     hc_reg <= cfg_data[39:0];
                default: ;
            endcase
        end
    end

    logic        [15:0] t1;
    logic signed [15:0] t2, t3;
    logic        [15:0] p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
    logic        [7:0]  h1, h3;
    logic signed [15:0] h2, h4, h5;
    logic signed [7:0]  h6;

    assign t1 = tc_reg[15:0];
    assign t2 = tc_reg[31:16];
    assign t3 = tc_reg[47:32];
    assign p1 = pl_reg[15:0];
    assign p2 = pl_reg[31:16];
    assign p3 = pl_reg[47:32];
    assign p4 = pl_reg[63:48];
    assign p5 = ph_reg[15:0];
    assign p6 = ph_reg[31:16];
    assign p7 = ph_reg[47:32];
    assign p8 = ph_reg[63:48];
    assign p9 = mx_reg[15:0];
    assign h1 = mx_reg[23:16];
    assign h2 = mx_reg[39:24];
    assign h3 = mx_reg[47:40];
    assign h4 = hc_reg[15:0];
    assign h5 = hc_reg[31:16];
    assign h6 = hc_reg[39:32];

    // ------------------------------------------------------------------
    // Flow control: the pipeline moves unless the output buffer is full
    logic [1:0] cnt_reg;
    logic       adv;

    assign adv      = (cnt_reg != 2'd2);
    assign s_tready = adv;

    logic vld_reg [1:LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= LAST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[1] <= s_tvalid;
            for (int k = 2; k <= LAST; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Raw field carries
    logic [19:0] rt_in;
    logic [19:0] rp_in;
    logic [15:0] rh_in;
    logic [19:0] rp_reg [1:9];
    logic [15:0] rh_reg [1:5];

    assign rt_in = s_tdata[19:0];
    assign rp_in = s_tdata[39:20];
    assign rh_in = s_tdata[55:40];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rp_reg[1] <= rp_in;
            for (int k = 2; k <= 9; k++)
            begin
                rp_reg[k] <= rp_reg[k-1];
            end
            rh_reg[1] <= rh_in;
            for (int k = 2; k <= 5; k++)
            begin
                rh_reg[k] <= rh_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Temperature, stages 1 to 4
    logic signed [17:0] ma_c;
    logic signed [17:0] d_c;
    logic signed [33:0] ta_c;
    logic signed [35:0] dd_c;
    logic signed [33:0] s1_ta_reg;
    logic signed [35:0] s1_dd_reg;

    assign ma_c = $signed({1'b0, rt_in[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign d_c  = $signed({2'b0, rt_in[19:4]}) - $signed({2'b0, t1});
    assign ta_c = ma_c * t2;
    assign dd_c = d_c * d_c;

    logic signed [31:0] a_sh;
    logic signed [31:0] dd_sh;
    logic signed [47:0] bm_c;
    logic        [31:0] s2_a_reg;
    logic        [47:0] s2_bm_reg;

    assign a_sh  = $signed(s1_ta_reg[31:0]) >>> 11;
    assign dd_sh = $signed(s1_dd_reg[31:0]) >>> 12;
    assign bm_c  = dd_sh * t3;

    logic signed [31:0] b_sh;
    logic        [31:0] s3_tf_reg;

    assign b_sh = $signed(s2_bm_reg[31:0]) >>> 14;

    logic [31:0] tf5_c;
    logic [31:0] temp_c;
    logic [63:0] s4_e_reg;
    logic [31:0] s4_hv_reg;
    logic [31:0] temp_reg [4:LAST];

    assign tf5_c  = {s3_tf_reg[29:0], 2'b0} + s3_tf_reg + 32'd128;
    assign temp_c = $signed(tf5_c) >>> 8;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ta_reg   <= ta_c;
            s1_dd_reg   <= dd_c;
            s2_a_reg    <= a_sh;
            s2_bm_reg   <= bm_c;
            s3_tf_reg   <= s2_a_reg + b_sh;
            temp_reg[4] <= temp_c;
            s4_e_reg    <= {{32{s3_tf_reg[31]}}, s3_tf_reg} - esc_pkg::T_FINE_OFS;
            s4_hv_reg   <= s3_tf_reg - esc_pkg::H_OFS;
            for (int k = 5; k <= LAST; k++)
            begin
                temp_reg[k] <= temp_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Humidity, stages 5 to 14
    logic signed [47:0] h5v_c;
    logic signed [39:0] h6v_c;
    logic        [39:0] h3v_c;
    logic [31:0] s5_h5v_reg, s5_h6_reg, s5_h3_reg;

    assign h5v_c = h5 * $signed(s4_hv_reg);
    assign h6v_c = $signed(s4_hv_reg) * h6;
    assign h3v_c = s4_hv_reg * h3;

    logic [31:0] xa_c;
    logic [31:0] x_c;
    logic [31:0] y1_c;
    logic [31:0] y2_c;
    logic [31:0] h3_sh;
    logic [31:0] s6_y1_reg, s6_y2_reg;
    logic [31:0] x_reg [6:10];

    assign xa_c  = {2'b0, rh_reg[5], 14'b0} - {h4[11:0], 20'b0} - s5_h5v_reg
                 + esc_pkg::H_RND14;
    assign x_c   = $signed(xa_c) >>> 15;
    assign y1_c  = $signed(s5_h6_reg) >>> 10;
    assign h3_sh = $signed(s5_h3_reg) >>> 11;
    assign y2_c  = h3_sh + esc_pkg::H_RND_H3;

    logic [63:0] yy_c;
    logic [31:0] s7_yy_reg;
    logic [31:0] yy_sh;
    logic [31:0] s8_y3_reg;
    logic signed [47:0] y3h2_c;
    logic [31:0] s9_m_reg;
    logic [31:0] ym_c;
    logic [31:0] y_c;
    logic [31:0] s10_y_reg;

    assign yy_c   = s6_y1_reg * s6_y2_reg;
    assign yy_sh  = $signed(s7_yy_reg) >>> 10;
    assign y3h2_c = $signed(s8_y3_reg) * h2;
    assign ym_c   = s9_m_reg + esc_pkg::H_RND_H2;
    assign y_c    = $signed(ym_c) >>> 14;

    logic [63:0] xy_c;
    logic [31:0] s11_v_reg;
    logic signed [31:0] w_c;
    logic signed [63:0] ww_c;
    logic [31:0] s12_ww_reg, s12_v_reg;
    logic signed [31:0] ww_sh;
    logic signed [40:0] ch1_c;
    logic [31:0] s13_c_reg, s13_v_reg;

    assign xy_c  = x_reg[10] * s10_y_reg;
    assign w_c   = $signed(s11_v_reg) >>> 15;
    assign ww_c  = w_c * w_c;
    assign ww_sh = $signed(s12_ww_reg) >>> 7;
    assign ch1_c = ww_sh * $signed({1'b0, h1});

    logic [31:0] c_sh;
    logic [31:0] vv_c;
    logic [31:0] vcl_c;
    logic [esc_pkg::HUM_W-1:0] hum_reg [14:LAST];

    assign c_sh = $signed(s13_c_reg) >>> 4;
    assign vv_c = s13_v_reg - c_sh;

    // clamp to 0 .. H_MAX
    always_comb
    begin
        if (vv_c[31])
        begin
            vcl_c = '0;
        end
        else if (vv_c > esc_pkg::H_MAX)
        begin
            vcl_c = esc_pkg::H_MAX;
        end
        else
        begin
            vcl_c = vv_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_h5v_reg  <= h5v_c[31:0];
            s5_h6_reg   <= h6v_c[31:0];
            s5_h3_reg   <= h3v_c[31:0];
            x_reg[6]    <= x_c;
            s6_y1_reg   <= y1_c;
            s6_y2_reg   <= y2_c;
            for (int k = 7; k <= 10; k++)
            begin
                x_reg[k] <= x_reg[k-1];
            end
            s7_yy_reg   <= yy_c[31:0];
            s8_y3_reg   <= yy_sh + esc_pkg::H_BIAS;
            s9_m_reg    <= y3h2_c[31:0];
            s10_y_reg   <= y_c;
            s11_v_reg   <= xy_c[31:0];
            s12_ww_reg  <= ww_c[31:0];
            s12_v_reg   <= s11_v_reg;
            s13_c_reg   <= ch1_c[31:0];
            s13_v_reg   <= s12_v_reg;
            hum_reg[14] <= vcl_c[28:12];
            for (int k = 15; k <= LAST; k++)
            begin
                hum_reg[k] <= hum_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Pressure, stages 5 to 13: divisor and dividend
    logic [63:0] p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;

    assign p2x = {{48{p2[15]}}, p2};
    assign p3x = {{48{p3[15]}}, p3};
    assign p4x = {{48{p4[15]}}, p4};
    assign p5x = {{48{p5[15]}}, p5};
    assign p6x = {{48{p6[15]}}, p6};
    assign p7x = {{48{p7[15]}}, p7};
    assign p8x = {{48{p8[15]}}, p8};
    assign p9x = {{48{p9[15]}}, p9};

    logic [63:0] sq_m, ep5_m, ep2_m;

    esc_mul u_mul_ee  (.clk(clk), .en(adv), .a(s4_e_reg), .b(s4_e_reg), .p(sq_m));
    esc_mul u_mul_ep5 (.clk(clk), .en(adv), .a(s4_e_reg), .b(p5x), .p(ep5_m));
    esc_mul u_mul_ep2 (.clk(clk), .en(adv), .a(s4_e_reg), .b(p2x), .p(ep2_m));

    logic [63:0] sq6_m, sq3_m;
    logic [63:0] s7_ep5_reg, s8_ep5_reg, s7_ep2_reg, s8_ep2_reg;

    esc_mul u_mul_sq6 (.clk(clk), .en(adv), .a(sq_m), .b(p6x), .p(sq6_m));
    esc_mul u_mul_sq3 (.clk(clk), .en(adv), .a(sq_m), .b(p3x), .p(sq3_m));

    logic [63:0] sq3_sh;
    logic [63:0] s9_v2_reg, s9_v1b_reg;
    logic [63:0] pn_c;
    logic [63:0] s10_x_reg, s10_nm_reg;

    assign sq3_sh = $signed(sq3_m) >>> 8;
    assign pn_c   = esc_pkg::P_BASE - {44'b0, rp_reg[9]};

    logic [63:0] p1_m, sc_m;
    logic [63:0] v1c_c;
    logic [63:0] s13_num_reg, s13_den_reg;
    logic        inv_reg [13:LAST];

    esc_mul u_mul_p1 (.clk(clk), .en(adv), .a(s10_x_reg), .b({48'b0, p1}), .p(p1_m));
    esc_mul u_mul_sc (.clk(clk), .en(adv), .a(s10_nm_reg), .b(esc_pkg::P_SCALE),
                      .p(sc_m));

    assign v1c_c = $signed(p1_m) >>> 33;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_ep5_reg   <= ep5_m;
            s8_ep5_reg   <= s7_ep5_reg;
            s7_ep2_reg   <= ep2_m;
            s8_ep2_reg   <= s7_ep2_reg;
            s9_v2_reg    <= sq6_m + {s8_ep5_reg[46:0], 17'b0} + {p4x[28:0], 35'b0};
            s9_v1b_reg   <= sq3_sh + {s8_ep2_reg[51:0], 12'b0};
            s10_x_reg    <= s9_v1b_reg + 64'h0000_8000_0000_0000;
            s10_nm_reg   <= {pn_c[32:0], 31'b0} - s9_v2_reg;
            s13_num_reg  <= sc_m;
            s13_den_reg  <= v1c_c;
            inv_reg[13]  <= (v1c_c == 64'd0);
            for (int k = 14; k <= LAST; k++)
            begin
                inv_reg[k] <= inv_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Pressure division, stages 14 to 79
    logic [63:0] q_d;

    esc_div u_div
    (
        .clk (clk),
        .en  (adv),
        .num (s13_num_reg),
        .den (s13_den_reg),
        .quo (q_d)
    );

    // ------------------------------------------------------------------
    // Pressure correction, stages 80 to 84
    logic [63:0] q_sh;
    logic [63:0] p9s_m, p8q_m;
    logic [63:0] q80_reg, q81_reg, q82_reg, q83_reg;
    logic [63:0] p8q82_reg, p8q83_reg;
    logic [63:0] q81_sh;
    logic [63:0] ss_m;

    assign q_sh   = $signed(q_d) >>> 13;
    assign q81_sh = $signed(q81_reg) >>> 13;

    esc_mul u_mul_p9s (.clk(clk), .en(adv), .a(p9x), .b(q_sh), .p(p9s_m));
    esc_mul u_mul_p8q (.clk(clk), .en(adv), .a(p8x), .b(q_d), .p(p8q_m));
    esc_mul u_mul_ss  (.clk(clk), .en(adv), .a(p9s_m), .b(q81_sh), .p(ss_m));

    logic [63:0] ss_sh;
    logic [63:0] p8q_sh;
    logic [63:0] s84_sum_reg;

    assign ss_sh  = $signed(ss_m) >>> 25;
    assign p8q_sh = $signed(p8q83_reg) >>> 19;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q80_reg     <= q_d;
            q81_reg     <= q80_reg;
            q82_reg     <= q81_reg;
            q83_reg     <= q82_reg;
            p8q82_reg   <= p8q_m;
            p8q83_reg   <= p8q82_reg;
            s84_sum_reg <= q83_reg + ss_sh + p8q_sh;
        end
    end

    // final shift, offset and saturation
    logic signed [63:0] sum_sh;
    logic signed [63:0] pf_c;
    logic        [31:0] psat_c;
    logic        [31:0] pout_c;

    assign sum_sh = $signed(s84_sum_reg) >>> 8;
    assign pf_c   = sum_sh + $signed({p7x[59:0], 4'b0});

    always_comb
    begin
        if (pf_c > 64'sd2147483647)
        begin
            psat_c = 32'h7FFF_FFFF;
        end
        else if (pf_c < -64'sd2147483648)
        begin
            psat_c = 32'h8000_0000;
        end
        else
        begin
            psat_c = pf_c[31:0];
        end
    end

    assign pout_c = inv_reg[LAST] ? 32'd0 : psat_c;

    // ------------------------------------------------------------------
    // Two-entry output buffer
    logic [87:0] ob_data_reg [2];
    logic        ob_user_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic        push;
    logic        pop;

    assign push = adv && vld_reg[LAST];
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ob_data_reg[wr_ptr_reg] <= {7'b0, hum_reg[LAST], pout_c, temp_reg[LAST]};
            ob_user_reg[wr_ptr_reg] <= inv_reg[LAST];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = ob_data_reg[rd_ptr_reg];
    assign m_tuser  = ob_user_reg[rd_ptr_reg];

endmodule

/* src/esc_checker.sv */
// Port-level checks for the compensation top level, attached by bind.
// Depends on esc_pkg and environmental_sensor_compensation_top.
module esc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input is refused only when results are waiting
    a_backp: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input blocked with empty output");

    // zero divisor forces zero pressure
    a_inv: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[63:32] == 32'd0)
        else $error("invalid pressure not zero");

    // humidity stays within its clamp
    a_hum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[80:64] <= esc_pkg::HUM_LIMIT)
        else $error("humidity above limit");

endmodule

bind environmental_sensor_compensation_top esc_checker u_esc_checker (.*);
